// File: design/swpsc_pkg.sv
// ----------------------------------------------------------------------------
// swpsc_pkg: shared types and constants for the pair-sum checker
// Value and sum types, status codes, register map and the chain command.
// ----------------------------------------------------------------------------
package swpsc_pkg;

  localparam int VAL_W          = 48;
  localparam int CFG_W          = 6;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 3;
  localparam int MAX_WINDOW_DEF = 32;
  localparam int MIN_WINDOW     = 2;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd25;

  // register index (byte address bit 2)
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  localparam logic [1:0] STATUS_PREAMBLE = 2'd0;
  localparam logic [1:0] STATUS_PAIR     = 2'd1;
  localparam logic [1:0] STATUS_NO_PAIR  = 2'd2;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic signed [VAL_W:0]   sum_t;

  typedef struct packed {
    logic   shift;
    value_t shift_value;
    logic   probe_valid;
    sum_t   probe;
  } chain_cmd_t;

endpackage

// File: design/swpsc_if.sv
// ----------------------------------------------------------------------------
// swpsc_if: stream channels of the pair-sum checker
// Input sample channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swpsc_in_if;
  import swpsc_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   restart;

  modport source (output valid, value, restart, input ready);
  modport sink   (input valid, value, restart, output ready);
endinterface

interface swpsc_out_if;
  import swpsc_pkg::*;

  logic       valid;
  logic       ready;
  value_t     echo_value;
  logic [1:0] status;
  logic       first_bad;

  modport source (output valid, echo_value, status, first_bad, input ready);
  modport sink   (input valid, echo_value, status, first_bad, output ready);
endinterface

// File: design/swpsc_cell.sv
// ----------------------------------------------------------------------------
// swpsc_cell: one window cell
// Holds one stored value, shifts from its neighbor and matches the probe.
// ----------------------------------------------------------------------------
module swpsc_cell (
  input  logic              clk,
  input  logic              shift,
  input  swpsc_pkg::value_t prev_value,
  input  logic              cmp_en,
  input  swpsc_pkg::sum_t   probe,
  output swpsc_pkg::value_t value,
  output logic              hit
);
  import swpsc_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= prev_value;
    end
  end

  // probe carries target minus the broadcast entry, one bit wider
  assign hit = cmp_en && (sum_t'(value) == probe);

endmodule

// File: design/swpsc_chain.sv
// ----------------------------------------------------------------------------
// swpsc_chain: row of window cells
// Cell k holds the value taken k+1 transactions ago; all cells compare in
// parallel against the probe, limited to positions between lo and hi.
// ----------------------------------------------------------------------------
module swpsc_chain #(
  parameter int MAX_WINDOW = swpsc_pkg::MAX_WINDOW_DEF,
  parameter int IW         = $clog2(MAX_WINDOW),
  parameter int LW         = $clog2(MAX_WINDOW + 1)
) (
  input  logic                  clk,
  input  swpsc_pkg::chain_cmd_t cmd,
  input  logic [IW-1:0]         lo,
  input  logic [LW-1:0]         hi,
  input  logic [IW-1:0]         rd_idx,
  output swpsc_pkg::value_t     rd_value,
  output logic                  any_hit
);
  import swpsc_pkg::*;

  value_t                vals [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] hits;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    localparam logic [LW-1:0] POS = LW'(k);
    value_t prev;
    logic   en;

    if (k == 0) begin : g_head
      assign prev = cmd.shift_value;
    end else begin : g_body
      assign prev = vals[k-1];
    end

    assign en = cmd.probe_valid && (POS > LW'(lo)) && (POS < hi);

    swpsc_cell u_cell (
      .clk        (clk),
      .shift      (cmd.shift),
      .prev_value (prev),
      .cmp_en     (en),
      .probe      (cmd.probe),
      .value      (vals[k]),
      .hit        (hits[k])
    );
  end

  assign rd_value = vals[rd_idx];
  assign any_hit  = |hits;

endmodule

// File: design/sliding_window_pair_sum_check.sv
// ----------------------------------------------------------------------------
// sliding_window_pair_sum_check: sliding-window pair-sum checker
// Checks each value against pairs of the preceding window_length values.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  sample   | in  | valid/ready          | value[47:0] signed, restart
//  result   | out | valid/ready          | echo_value[47:0], status[1:0], first_bad
//  apb      | in  | psel/penable, pready | window_length at byte address 0
//
// A checked value is taken in idle. Then, in search, every entry of the effective
// window but the last is broadcast, one per cycle. A flush step drains the compare
// stage and the done step registers the result; idle then takes the next
// transaction. A preamble value goes from idle straight to the done step.
// A new transaction is taken while the previous result waits at the output;
// a stalled output holds the block in its final step.
// Reset (rst, synchronous) clears fill count and flags; window_length -> 25.
// ----------------------------------------------------------------------------
module sliding_window_pair_sum_check #(
  parameter int MAX_WINDOW = swpsc_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  swpsc_in_if.sink                        sample,
  swpsc_out_if.source                     result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swpsc_pkg::ADDR_W-1:0]    paddr,
  input  logic [swpsc_pkg::DATA_W-1:0]    pwdata,
  output logic [swpsc_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);
  import swpsc_pkg::*;

  localparam int IW = $clog2(MAX_WINDOW);
  localparam int LW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_FLUSH, S_DONE} state_t;

  state_t            state;
  logic [CFG_W-1:0]  window_length;
  logic [LW-1:0]     fill;
  logic              invalid_seen;
  value_t            target;
  logic [LW-1:0]     len;
  logic              searched;
  logic [IW-1:0]     idx;
  sum_t              probe;
  logic              probe_valid;
  logic [IW-1:0]     probe_lo;
  logic              found;

  logic              res_valid;
  value_t            res_value;
  logic [1:0]        res_status;
  logic              res_first;

  logic [LW-1:0]     len_eff;
  logic [LW-1:0]     fill_start;
  logic              take;
  logic              out_free;
  logic              cfg_wr;
  chain_cmd_t        cmd;
  value_t            rd_value;
  logic              any_hit;

  always_comb begin
    if (window_length < CFG_W'(MIN_WINDOW)) begin
      len_eff = LW'(MIN_WINDOW);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      len_eff = LW'(MAX_WINDOW);
    end else begin
      len_eff = LW'(window_length);
    end
  end

  assign sample.ready = (state == S_IDLE);
  assign take         = sample.valid && sample.ready;
  assign out_free     = !res_valid || result.ready;
  assign fill_start   = sample.restart ? '0 : fill;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[ADDR_W-1] == REG_WINDOW_LENGTH) ? DATA_W'(window_length) : '0;

  assign cmd.shift       = (state == S_DONE) && out_free;
  assign cmd.shift_value = target;
  assign cmd.probe_valid = probe_valid;
  assign cmd.probe       = probe;

  swpsc_chain #(
    .MAX_WINDOW (MAX_WINDOW),
    .IW         (IW),
    .LW         (LW)
  ) u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .lo       (probe_lo),
    .hi       (len),
    .rd_idx   (idx),
    .rd_value (rd_value),
    .any_hit  (any_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= WINDOW_RESET;
      fill          <= '0;
      invalid_seen  <= 1'b0;
      probe_valid   <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_wr && paddr[ADDR_W-1] == REG_WINDOW_LENGTH) begin
        window_length <= pwdata[CFG_W-1:0];
      end
      // a result leaving in the cycle a new one is loaded is handled in S_DONE
      if (res_valid && result.ready && !cmd.shift) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          probe_valid <= 1'b0;
          if (take) begin
            fill     <= fill_start;
            target   <= sample.value;
            len      <= len_eff;
            idx      <= '0;
            found    <= 1'b0;
            searched <= (fill_start >= len_eff);
            if (sample.restart) begin
              invalid_seen <= 1'b0;
            end
            state <= (fill_start >= len_eff) ? S_SEARCH : S_DONE;
          end
        end
        S_SEARCH: begin
          // broadcast entry idx as complement; cells after it compare next cycle
          probe       <= sum_t'(target) - sum_t'(rd_value);
          probe_valid <= 1'b1;
          probe_lo    <= idx;
          idx         <= idx + 1'b1;
          found       <= found | any_hit;
          if (LW'(idx) == len - LW'(2)) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          probe_valid <= 1'b0;
          found       <= found | any_hit;
          state       <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_value <= target;
            res_first <= searched && !found && !invalid_seen;
            if (!searched) begin
              res_status <= STATUS_PREAMBLE;
            end else if (found) begin
              res_status <= STATUS_PAIR;
            end else begin
              res_status   <= STATUS_NO_PAIR;
              invalid_seen <= 1'b1;
            end
            if (fill != LW'(MAX_WINDOW)) begin
              fill <= fill + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid      = res_valid;
  assign result.echo_value = res_value;
  assign result.status     = res_status;
  assign result.first_bad  = res_first;

endmodule
